FILE: design/per_channel_weight_statistics_defines.svh
// Assertion helpers for the top-level file that checks this block.
`ifndef PER_CHANNEL_WEIGHT_STATISTICS_DEFINES_SVH
`define PER_CHANNEL_WEIGHT_STATISTICS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcws assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcws assertion failed");

`endif

FILE: design/pcws_pkg.sv
package pcws_pkg;

  // Default sizes of the sample store.
  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned SAMPLES_DEF  = 64;

  // Fixed field widths.
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned PCT_W    = 16;

  // Percentage scale: hundredths of a percent.
  localparam int unsigned PCT_SCALE = 10000;
  localparam int unsigned SCALE_W   = 14;
  localparam logic [PCT_W-1:0] PCT_MAX = 16'hFFFF;

  // Which quotient the shared divider is producing.
  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_CORR = 2'd1,
    DIV_VAR  = 2'd2,
    DIV_PCT  = 2'd3
  } div_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    lookup;
    logic    rd_en;
    logic    sq_pass;
    logic    div_start;
    div_op_e div_op;
    logic    root_start;
    logic    mul;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lk_zero;
    logic rd_last;
    logic pipe_idle;
    logic n_one;
    logic div_done;
    logic root_done;
    logic tgt_zero;
  } status_t;

endpackage

FILE: design/pcws_ram.sv
module pcws_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pcws_div.sv
module pcws_div #(
  parameter int unsigned DVW = 54,
  parameter int unsigned DSW = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quot_o,
  output logic [DSW-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(DVW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DSW-1:0]  rem_q, dvs_q;
  logic [DVW-1:0]  quo_q;
  logic [DSW:0]    shifted;
  logic            ge;
  logic            last;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem_q, quo_q[DVW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign last    = cnt_q == CNTW'(DVW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DSW'(shifted - {1'b0, dvs_q}) : shifted[DSW-1:0];
      quo_q <= {quo_q[DVW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/pcws_dp.sv
module pcws_dp #(
  parameter int unsigned CHANNELS = pcws_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLES  = pcws_pkg::SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcws_pkg::cmd_t                  cmd_i,
  output pcws_pkg::status_t               status_o,
  input  logic                            opcode_i,
  input  logic [pcws_pkg::CHAN_W-1:0]     channel_i,
  input  logic [pcws_pkg::WEIGHT_W-1:0]   weight_i,
  input  logic                            retried_i,
  input  logic [pcws_pkg::WEIGHT_W-1:0]   target_i,
  input  logic                            restart_hour_max_i,
  input  logic                            restart_hour_min_i,
  output logic [pcws_pkg::COUNT_W-1:0]    count_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   mean_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   deviation_o,
  output logic [pcws_pkg::PCT_W-1:0]      deviation_percent_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   batch_max_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   batch_min_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   hour_max_o,
  output logic [pcws_pkg::WEIGHT_W-1:0]   hour_min_o,
  output logic                            zero_target_o
);

  localparam int unsigned WW    = pcws_pkg::WEIGHT_W;
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW    = $clog2(SAMPLES);
  localparam int unsigned CW    = $clog2(SAMPLES + 1);
  localparam int unsigned DEPTH = CHANNELS * SAMPLES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUMW  = WW + IW;
  localparam int unsigned DVW   = 2 * WW + IW;
  localparam int unsigned RW    = (DVW + 1) / 2;
  localparam int unsigned SQW   = 2 * RW;
  localparam int unsigned SRW   = RW + 2;
  localparam int unsigned RCW   = $clog2(RW);
  localparam int unsigned PMW   = RW + pcws_pkg::SCALE_W;

  // Latched input word.
  logic          op_q, ret_q, rmax_q, rmin_q;
  logic [pcws_pkg::CHAN_W-1:0] ch_q;
  logic [WW-1:0] w_q, tgt_q;

  // Per-channel state.
  logic [CW-1:0] cnt_q [CHANNELS];
  logic [WW-1:0] bhi_q [CHANNELS];
  logic [WW-1:0] blo_q [CHANNELS];
  logic [WW-1:0] hhi_q [CHANNELS];
  logic [WW-1:0] hlo_q [CHANNELS];

  // Work registers for one item.
  logic [CW-1:0]    n_q, idx_q, r_q;
  logic             zero_q, rv_q, pv_q;
  logic [SUMW-1:0]  sum_q;
  logic [DVW-1:0]   q_q, corr_q, var_q;
  logic [WW-1:0]    x_q, m_q, mean_q;
  logic [2*WW-1:0]  prod_q;
  logic [PMW-1:0]   pm_q;
  logic [pcws_pkg::PCT_W-1:0] pct_q;

  // Square root unit.
  logic [SQW-1:0]   rad_q;
  logic [RW-1:0]    root_q;
  logic [SRW-1:0]   srem_q;
  logic [RCW-1:0]   rcnt_q;
  logic             rbusy_q, rdone_q;

  logic [CHW-1:0]   ch_idx;
  logic             ch_bad;
  logic [CW-1:0]    cur_n, n_new;
  logic             lk_zero, we;
  logic [AW-1:0]    base, waddr, raddr;
  logic [WW-1:0]    rdata, dif;
  logic             rd_last;
  logic [DVW-1:0]   dvd, ss, quot;
  logic [WW-1:0]    dvs, rem;
  logic             div_done;
  logic [2*CW-1:0]  rr;
  logic [CW:0]      rnd_sum;
  logic [SRW+1:0]   remsh, trial;
  logic             rge;
  logic [WW-1:0]    bh_n, bl_n, hh_n, hl_n, hh0, hl0;
  logic             tgt_zero;

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      ch_q   <= channel_i;
      w_q    <= weight_i;
      ret_q  <= retried_i;
      tgt_q  <= target_i;
      rmax_q <= restart_hour_max_i;
      rmin_q <= restart_hour_min_i;
    end
  end

  // Count lookup and buffer wrap.
  assign ch_idx  = ch_q[CHW-1:0];
  assign ch_bad  = {1'b0, ch_q} >= (pcws_pkg::CHAN_W + 1)'(CHANNELS);
  assign cur_n   = cnt_q[ch_idx];
  assign n_new   = ret_q ? cur_n :
                   ((cur_n >= CW'(SAMPLES)) ? CW'(1) : CW'(cur_n + 1'b1));
  assign lk_zero = op_q || ch_bad || (n_new == '0);
  assign we      = cmd_i.lookup && !op_q && !ch_bad && !ret_q;

  // Store addressing: channel base plus position.
  assign base  = AW'(ch_idx) * AW'(SAMPLES);
  assign waddr = base + AW'(CW'(n_new - 1'b1));
  assign raddr = base + AW'(idx_q);

  pcws_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (w_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_last = CW'(idx_q + 1'b1) == n_q;
  assign dif     = (rdata >= m_q) ? rdata - m_q : m_q - rdata;

  // Divider operand selection.
  assign rr = (2*CW)'(r_q) * (2*CW)'(r_q) + (2*CW)'(n_q) - 1'b1;
  assign ss = (q_q >= corr_q) ? q_q - corr_q : '0;

  always_comb begin
    dvd = DVW'(sum_q);
    dvs = WW'(n_q);
    case (cmd_i.div_op)
      pcws_pkg::DIV_MEAN: begin
        dvd = DVW'(sum_q);
        dvs = WW'(n_q);
      end
      pcws_pkg::DIV_CORR: begin
        dvd = DVW'(rr);
        dvs = WW'(n_q);
      end
      pcws_pkg::DIV_VAR: begin
        dvd = ss;
        dvs = WW'(CW'(n_q - 1'b1));
      end
      pcws_pkg::DIV_PCT: begin
        dvd = DVW'(pm_q);
        dvs = tgt_q;
      end
      default: begin
        dvd = DVW'(sum_q);
        dvs = WW'(n_q);
      end
    endcase
  end

  pcws_div #(
    .DVW (DVW),
    .DSW (WW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Round to nearest: add one when the remainder reaches half the count.
  assign rnd_sum = (CW+1)'(CW'(rem)) + (CW+1)'(n_q >> 1);

  // Square root step: two radicand bits per cycle.
  assign remsh = {srem_q, rad_q[SQW-1 -: 2]};
  assign trial = (SRW+2)'({root_q, 2'b01});
  assign rge   = remsh >= trial;

  // Pipeline control flags and item bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      idx_q   <= '0;
      rbusy_q <= 1'b0;
      rdone_q <= 1'b0;
      rcnt_q  <= '0;
      zero_q  <= 1'b1;
      n_q     <= '0;
    end else begin
      rv_q    <= cmd_i.rd_en;
      pv_q    <= rv_q && cmd_i.sq_pass;
      rdone_q <= 1'b0;
      if (cmd_i.lookup) begin
        n_q    <= n_new;
        zero_q <= lk_zero;
        idx_q  <= '0;
      end else if (cmd_i.rd_en) begin
        idx_q <= rd_last ? '0 : CW'(idx_q + 1'b1);
      end
      if (cmd_i.root_start) begin
        rbusy_q <= 1'b1;
        rcnt_q  <= '0;
      end else if (rbusy_q) begin
        rcnt_q <= rcnt_q + 1'b1;
        if (rcnt_q == RCW'(RW - 1)) begin
          rbusy_q <= 1'b0;
          rdone_q <= 1'b1;
        end
      end
    end
  end

  // Accumulators, quotients and the root.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      sum_q  <= '0;
      q_q    <= '0;
      root_q <= '0;
    end else begin
      if (rv_q && !cmd_i.sq_pass) begin
        sum_q <= sum_q + SUMW'(rdata);
        x_q   <= rdata;
      end
      if (rv_q && cmd_i.sq_pass) begin
        prod_q <= dif * dif;
      end
      if (pv_q) begin
        q_q <= q_q + DVW'(prod_q);
      end
      if (cmd_i.root_start) begin
        rad_q  <= SQW'(var_q);
        root_q <= '0;
        srem_q <= '0;
      end else if (rbusy_q) begin
        rad_q  <= rad_q << 2;
        srem_q <= rge ? SRW'(remsh - trial) : SRW'(remsh);
        root_q <= {root_q[RW-2:0], rge};
      end
    end
    if (div_done) begin
      case (cmd_i.div_op)
        pcws_pkg::DIV_MEAN: begin
          m_q    <= quot[WW-1:0];
          r_q    <= CW'(rem);
          mean_q <= quot[WW-1:0] + WW'(rnd_sum >= (CW+1)'(n_q));
        end
        pcws_pkg::DIV_CORR: corr_q <= quot;
        pcws_pkg::DIV_VAR:  var_q  <= quot;
        pcws_pkg::DIV_PCT: begin
          pct_q <= (quot > DVW'(pcws_pkg::PCT_MAX)) ? pcws_pkg::PCT_MAX :
                   quot[pcws_pkg::PCT_W-1:0];
        end
        default: corr_q <= quot;
      endcase
    end
    if (cmd_i.mul) begin
      pm_q <= PMW'(root_q) * PMW'(pcws_pkg::PCT_SCALE);
    end
  end

  // New extremes from the newest stored sample.
  always_comb begin
    hh0 = rmax_q ? x_q : hhi_q[ch_idx];
    hl0 = rmin_q ? x_q : hlo_q[ch_idx];
    if (n_q == CW'(1)) begin
      bh_n = x_q;
      bl_n = x_q;
      hh_n = x_q;
      hl_n = x_q;
    end else begin
      bh_n = (x_q > bhi_q[ch_idx]) ? x_q : bhi_q[ch_idx];
      bl_n = (x_q < blo_q[ch_idx]) ? x_q : blo_q[ch_idx];
      hh_n = (x_q > hh0) ? x_q : hh0;
      hl_n = (x_q < hl0) ? x_q : hl0;
    end
  end

  assign tgt_zero = tgt_q == '0;

  // Per-channel counts and extremes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_q[i] <= '0;
        bhi_q[i] <= '0;
        blo_q[i] <= '0;
        hhi_q[i] <= '0;
        hlo_q[i] <= '0;
      end
    end else begin
      if (cmd_i.lookup && op_q) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_q[i] <= '0;
        end
      end else if (we) begin
        cnt_q[ch_idx] <= n_new;
      end
      if (cmd_i.load_out && !zero_q) begin
        bhi_q[ch_idx] <= bh_n;
        blo_q[ch_idx] <= bl_n;
        hhi_q[ch_idx] <= hh_n;
        hlo_q[ch_idx] <= hl_n;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (zero_q) begin
        count_o             <= '0;
        mean_o              <= '0;
        deviation_o         <= '0;
        deviation_percent_o <= '0;
        batch_max_o         <= '0;
        batch_min_o         <= '0;
        hour_max_o          <= '0;
        hour_min_o          <= '0;
        zero_target_o       <= 1'b0;
      end else begin
        count_o             <= pcws_pkg::COUNT_W'(n_q);
        mean_o              <= mean_q;
        deviation_o         <= WW'(root_q);
        deviation_percent_o <= tgt_zero ? pcws_pkg::PCT_MAX : pct_q;
        batch_max_o         <= bh_n;
        batch_min_o         <= bl_n;
        hour_max_o          <= hh_n;
        hour_min_o          <= hl_n;
        zero_target_o       <= tgt_zero;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o           = '0;
    status_o.lk_zero   = lk_zero;
    status_o.rd_last   = rd_last;
    status_o.pipe_idle = !rv_q && !pv_q;
    status_o.n_one     = n_q == CW'(1);
    status_o.div_done  = div_done;
    status_o.root_done = rdone_q;
    status_o.tgt_zero  = tgt_zero;
  end

endmodule

FILE: design/pcws_ctrl.sv
module pcws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pcws_pkg::status_t status_i,
  output pcws_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'h001,
    ST_LOOKUP    = 12'h002,
    ST_SUM_RD    = 12'h004,
    ST_SUM_DRAIN = 12'h008,
    ST_DIV_GO    = 12'h010,
    ST_DIV_WAIT  = 12'h020,
    ST_SQ_RD     = 12'h040,
    ST_SQ_DRAIN  = 12'h080,
    ST_ROOT_GO   = 12'h100,
    ST_ROOT_WAIT = 12'h200,
    ST_MUL       = 12'h400,
    ST_FINISH    = 12'h800
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  pcws_pkg::div_op_e op_q, op_d;
  logic              out_valid_q, out_valid_d;

  // Sequencing of one item.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.div_op = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = status_i.lk_zero ? ST_FINISH : ST_SUM_RD;
      end
      ST_SUM_RD: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_SUM_DRAIN;
        end
      end
      ST_SUM_DRAIN: begin
        if (status_i.pipe_idle) begin
          op_d    = pcws_pkg::DIV_MEAN;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          unique case (op_q)
            pcws_pkg::DIV_MEAN: state_d = ST_SQ_RD;
            pcws_pkg::DIV_CORR: begin
              op_d    = pcws_pkg::DIV_VAR;
              state_d = ST_DIV_GO;
            end
            pcws_pkg::DIV_VAR: state_d = ST_ROOT_GO;
            pcws_pkg::DIV_PCT: state_d = ST_FINISH;
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_SQ_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.sq_pass = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_SQ_DRAIN;
        end
      end
      ST_SQ_DRAIN: begin
        cmd_o.sq_pass = 1'b1;
        if (status_i.pipe_idle) begin
          if (status_i.n_one) begin
            state_d = ST_MUL;
          end else begin
            op_d    = pcws_pkg::DIV_CORR;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_ROOT_GO: begin
        cmd_o.root_start = 1'b1;
        state_d = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (status_i.root_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (status_i.tgt_zero) begin
          state_d = ST_FINISH;
        end else begin
          op_d    = pcws_pkg::DIV_PCT;
          state_d = ST_DIV_GO;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid: set on load, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= pcws_pkg::DIV_MEAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/per_channel_weight_statistics.sv
// Per-channel weight statistics.
// Input channel: in_valid_i/in_ready_o carry one word: a weighed sample for one
// channel (opcode 0) or a clear of all sample counts (opcode 1).
// Output channel: out_valid_o/out_ready_i carry one result word per input word:
// count, rounded mean, sample deviation, deviation percent of target, and the
// batch and hourly extremes of the channel. Clears, empty channels and
// out-of-range channels give an all-zero word.
// One word is worked on at a time. With samples held, a word takes two passes over
// the sample memory read port, up to four quotients from the one-bit-per-cycle
// divider and the two-bit-per-cycle root. The result becomes valid in the same
// cycle as the next word can be taken.
// A finished word waits in the output register; a new input word is taken
// meanwhile, and its result is held back until the receiver takes the old one.
// Reset zeroes all counts and extremes; the sample memory needs no clearing.
`include "per_channel_weight_statistics_defines.svh"

module per_channel_weight_statistics #(
  parameter int unsigned CHANNELS = pcws_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLES  = pcws_pkg::SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [pcws_pkg::CHAN_W-1:0]   channel_i,
  input  logic [pcws_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                          retried_i,
  input  logic [pcws_pkg::WEIGHT_W-1:0] target_i,
  input  logic                          restart_hour_max_i,
  input  logic                          restart_hour_min_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcws_pkg::COUNT_W-1:0]  count_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] mean_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] deviation_o,
  output logic [pcws_pkg::PCT_W-1:0]    deviation_percent_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] batch_max_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] batch_min_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] hour_max_o,
  output logic [pcws_pkg::WEIGHT_W-1:0] hour_min_o,
  output logic                          zero_target_o
);

  pcws_pkg::cmd_t    cmd;
  pcws_pkg::status_t status;

  pcws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcws_dp #(
    .CHANNELS (CHANNELS),
    .SAMPLES  (SAMPLES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .opcode_i            (opcode_i),
    .channel_i           (channel_i),
    .weight_i            (weight_i),
    .retried_i           (retried_i),
    .target_i            (target_i),
    .restart_hour_max_i  (restart_hour_max_i),
    .restart_hour_min_i  (restart_hour_min_i),
    .count_o             (count_o),
    .mean_o              (mean_o),
    .deviation_o         (deviation_o),
    .deviation_percent_o (deviation_percent_o),
    .batch_max_o         (batch_max_o),
    .batch_min_o         (batch_min_o),
    .hour_max_o          (hour_max_o),
    .hour_min_o          (hour_min_o),
    .zero_target_o       (zero_target_o)
  );

  // Only one word is in flight: taking one closes the input side.
  `PCWS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A zero target always reports a saturated percentage.
  `PCWS_ASSERT_IMP(a_zero_target_sat, clk_i, rst_ni,
                   out_valid_o && zero_target_o,
                   deviation_percent_o == pcws_pkg::PCT_MAX)
  // With a real target, zero deviation gives zero percent.
  `PCWS_ASSERT_IMP(a_zero_dev_pct, clk_i, rst_ni,
                   out_valid_o && !zero_target_o && (deviation_o == '0),
                   deviation_percent_o == '0)

endmodule

FILE: tb/sv/per_channel_weight_statistics_tb.sv
`timescale 1ns / 1ps

module per_channel_weight_statistics_tb;

  localparam int unsigned NCH = pcws_pkg::CHANNELS_DEF;
  localparam int unsigned NSMP = pcws_pkg::SAMPLES_DEF;
  localparam int unsigned CHAN_W = pcws_pkg::CHAN_W;
  localparam int unsigned WEIGHT_W = pcws_pkg::WEIGHT_W;
  localparam int unsigned COUNT_W = pcws_pkg::COUNT_W;
  localparam int unsigned PCT_W = pcws_pkg::PCT_W;
  localparam int unsigned PCT_SCALE = pcws_pkg::PCT_SCALE;
  localparam logic [PCT_W-1:0] PCT_MAX = pcws_pkg::PCT_MAX;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam int unsigned STALL_LIMIT = 12000;
  localparam int unsigned HOLD_CYCLES = 2500;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [WEIGHT_W-1:0] mean;
    logic [WEIGHT_W-1:0] deviation;
    logic [PCT_W-1:0] deviation_percent;
    logic [WEIGHT_W-1:0] batch_max;
    logic [WEIGHT_W-1:0] batch_min;
    logic [WEIGHT_W-1:0] hour_max;
    logic [WEIGHT_W-1:0] hour_min;
    logic zero_target;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = OP_SAMPLE;
  logic [CHAN_W-1:0] channel_i = '0;
  logic [WEIGHT_W-1:0] weight_i = '0;
  logic retried_i = 1'b0;
  logic [WEIGHT_W-1:0] target_i = '0;
  logic restart_hour_max_i = 1'b0;
  logic restart_hour_min_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [COUNT_W-1:0] count_o;
  logic [WEIGHT_W-1:0] mean_o;
  logic [WEIGHT_W-1:0] deviation_o;
  logic [PCT_W-1:0] deviation_percent_o;
  logic [WEIGHT_W-1:0] batch_max_o;
  logic [WEIGHT_W-1:0] batch_min_o;
  logic [WEIGHT_W-1:0] hour_max_o;
  logic [WEIGHT_W-1:0] hour_min_o;
  logic zero_target_o;

  per_channel_weight_statistics dut (.*);

  // Clock: 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the per-channel state.
  logic [WEIGHT_W-1:0] weights_mem [NCH][NSMP];
  int unsigned held [NCH];
  logic [WEIGHT_W-1:0] bat_hi [NCH], bat_lo [NCH], hr_hi [NCH], hr_lo [NCH];

  stats_t expected_stats [$];
  int unsigned errors = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  // Update the mirrored state with one word and return the statistics it reports.
  function automatic stats_t weigh_word(logic op, logic [CHAN_W-1:0] ch, logic [WEIGHT_W-1:0] w,
                                        logic ret, logic [WEIGHT_W-1:0] tgt,
                                        logic rmax, logic rmin);
    stats_t s;
    longint unsigned n, sum, m, r, q, d, corr, ss, dev, pct, mean;
    logic [WEIGHT_W-1:0] x;
    s = '0;
    sum = 0;
    q = 0;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < NCH; i++) held[i] = 0;
      return s;
    end
    if (!ret) begin
      held[ch] = (held[ch] >= NSMP) ? 1 : held[ch] + 1;
      weights_mem[ch][held[ch]-1] = w;
    end
    n = held[ch];
    if (n == 0) return s;
    for (int i = 0; i < n; i++) sum += weights_mem[ch][i];
    m = sum / n;
    r = sum % n;
    for (int i = 0; i < n; i++) begin
      d = (weights_mem[ch][i] >= m) ? weights_mem[ch][i] - m : m - weights_mem[ch][i];
      q += d * d;
    end
    if (n == 1) begin
      dev = 0;
    end else begin
      corr = (r * r + n - 1) / n;
      ss = (q >= corr) ? q - corr : 0;
      dev = floor_root(ss / (n - 1));
    end
    // The newest stored sample drives all extremes.
    x = weights_mem[ch][n-1];
    if (n == 1) begin
      bat_hi[ch] = x;
      bat_lo[ch] = x;
      hr_hi[ch] = x;
      hr_lo[ch] = x;
    end else begin
      if (rmax) hr_hi[ch] = x;
      if (rmin) hr_lo[ch] = x;
      if (x > bat_hi[ch]) bat_hi[ch] = x;
      if (x < bat_lo[ch]) bat_lo[ch] = x;
      if (x > hr_hi[ch]) hr_hi[ch] = x;
      if (x < hr_lo[ch]) hr_lo[ch] = x;
    end
    if (tgt == 0) begin
      pct = PCT_MAX;
      s.zero_target = 1'b1;
    end else begin
      pct = dev * PCT_SCALE / tgt;
      if (pct > PCT_MAX) pct = PCT_MAX;
    end
    mean = (sum + n / 2) / n;
    s.count = n[COUNT_W-1:0];
    s.mean = mean[WEIGHT_W-1:0];
    s.deviation = dev[WEIGHT_W-1:0];
    s.deviation_percent = pct[PCT_W-1:0];
    s.batch_max = bat_hi[ch];
    s.batch_min = bat_lo[ch];
    s.hour_max = hr_hi[ch];
    s.hour_min = hr_lo[ch];
    return s;
  endfunction

  // Offer one word, after a random gap unless no_idle is set, and record its expected statistics on acceptance.
  task automatic send_word(logic op, logic [CHAN_W-1:0] ch, logic [WEIGHT_W-1:0] w, logic ret,
                           logic [WEIGHT_W-1:0] tgt, logic rmax, logic rmin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i = op;
    channel_i = ch;
    weight_i = w;
    retried_i = ret;
    target_i = tgt;
    restart_hour_max_i = rmax;
    restart_hour_min_i = rmin;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_stats.push_back(weigh_word(op, ch, w, ret, tgt, rmax, rmin));
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i = 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    stats_t e;
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_stats.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (count_o !== e.count) begin
          $error("count exp %0d got %0d", e.count, count_o); errors++;
        end
        if (mean_o !== e.mean) begin
          $error("mean exp %0d got %0d", e.mean, mean_o); errors++;
        end
        if (deviation_o !== e.deviation) begin
          $error("deviation exp %0d got %0d", e.deviation, deviation_o); errors++;
        end
        if (deviation_percent_o !== e.deviation_percent) begin
          $error("deviation_percent exp %0d got %0d", e.deviation_percent,
                 deviation_percent_o);
          errors++;
        end
        if (batch_max_o !== e.batch_max) begin
          $error("batch_max exp %0d got %0d", e.batch_max, batch_max_o); errors++;
        end
        if (batch_min_o !== e.batch_min) begin
          $error("batch_min exp %0d got %0d", e.batch_min, batch_min_o); errors++;
        end
        if (hour_max_o !== e.hour_max) begin
          $error("hour_max exp %0d got %0d", e.hour_max, hour_max_o); errors++;
        end
        if (hour_min_o !== e.hour_min) begin
          $error("hour_min exp %0d got %0d", e.hour_min, hour_min_o); errors++;
        end
        if (zero_target_o !== e.zero_target) begin
          $error("zero_target exp %0d got %0d", e.zero_target, zero_target_o); errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles with no word moving on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Clears, empty channels and a first sample.
  task automatic test_clear_and_empty();
    send_word(OP_CLEAR, 4'd0, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'd7, 24'd1234, 1'b1, 24'd1000, 1'b1, 1'b1);
    send_word(OP_SAMPLE, 4'd7, 24'd5000, 1'b0, 24'd5000, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'd7, 24'd5100, 1'b1, 24'd5000, 1'b0, 1'b0);
    send_word(OP_CLEAR, 4'hF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1);
    send_word(OP_SAMPLE, 4'd7, 24'd9, 1'b1, 24'd5000, 1'b0, 1'b0);
  endtask

  // Field extremes, zero target, saturating percentage and hourly restarts.
  task automatic test_field_extremes();
    send_word(OP_SAMPLE, 4'hF, 24'hFFFFFF, 1'b0, 24'hFFFFFF, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'hF, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'hF, 24'hFFFFFF, 1'b0, 24'd1, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'hF, 24'd0, 1'b1, 24'hFFFFFF, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'hF, 24'h800000, 1'b0, 24'h7FFFFF, 1'b1, 1'b0);
    send_word(OP_SAMPLE, 4'hF, 24'h800001, 1'b0, 24'h7FFFFF, 1'b0, 1'b1);
    send_word(OP_SAMPLE, 4'hF, 24'h7FFFFF, 1'b1, 24'd100, 1'b1, 1'b1);
    send_word(OP_SAMPLE, 4'd0, 24'd0, 1'b0, 24'd0, 1'b1, 1'b1);
    send_word(OP_SAMPLE, 4'd0, 24'd0, 1'b0, 24'd1, 1'b0, 1'b0);
    send_word(OP_SAMPLE, 4'd0, 24'd3, 1'b0, 24'd1, 1'b0, 1'b0);
  endtask

  // Long receiver hold-off while words keep coming, with no idling.
  task automatic test_output_backpressure();
    no_idle = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_word(OP_SAMPLE, 4'd9, 24'd10000 + 24'(i * 37), 1'b0, 24'd10000, 1'b0, 1'b0);
    no_idle = 1'b0;
  endtask

  // Fill one channel past its buffer depth so that it restarts at one.
  task automatic test_buffer_wrap();
    for (int i = 0; i < NSMP + 6; i++)
      send_word(OP_SAMPLE, 4'd5, 24'd20000 + 24'(i * 113), 1'b0, 24'd20000, 1'b0, 1'b0);
  endtask

  // Random words, mostly on a few channels so that buffers fill and wrap.
  task automatic test_random_traffic(int unsigned items);
    logic op, ret, rmax, rmin;
    logic [CHAN_W-1:0] ch;
    logic [WEIGHT_W-1:0] w, tgt;
    logic [CHAN_W-1:0] focus [3];
    focus = '{4'd2, 4'd10, 4'd13};
    for (int i = 0; i < items; i++) begin
      if (i % 200 == 100) no_idle = 1'b1;
      if (i % 200 == 140) no_idle = 1'b0;
      op = ($urandom_range(0, 149) == 0) ? OP_CLEAR : OP_SAMPLE;
      ch = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom) : focus[$urandom_range(0, 2)];
      case ($urandom_range(0, 3))
        0: tgt = 24'($urandom_range(0, 100));
        default: tgt = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: w = 24'($urandom);
        1: w = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
        default: w = tgt + 24'($urandom_range(0, 400)) - 24'd200;
      endcase
      ret = ($urandom_range(0, 7) == 0);
      rmax = ($urandom_range(0, 9) == 0);
      rmin = ($urandom_range(0, 9) == 0);
      send_word(op, ch, w, ret, tgt, rmax, rmin);
    end
  endtask

  initial begin
    int unsigned settle;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_clear_and_empty();
    test_field_extremes();
    test_output_backpressure();
    test_buffer_wrap();
    test_random_traffic(630);
    idle_input();
    while (expected_stats.size() != 0) @(negedge clk_i);
    settle = 0;
    while (settle < 600) begin
      @(negedge clk_i);
      settle++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/pcws_pkg.sv
design/pcws_ram.sv
design/pcws_div.sv
design/pcws_dp.sv
design/pcws_ctrl.sv
design/per_channel_weight_statistics.sv
tb/sv/per_channel_weight_statistics_tb.sv
